>>> rtl/core/two_touch_pinch_pan_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Two-touch pinch/pan tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_TOUCH_PINCH_PAN_TRACKER_TOP_MACROS_SVH
`define TWO_TOUCH_PINCH_PAN_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTPP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TTPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`endif

>>> rtl/core/ttpp_pkg.sv
// ----------------------------------------------------------------------------
// Tracker package
// Field widths, default parameters and shared types of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ttpp_pkg;

    localparam int ID_BITS_DEF    = 8;
    localparam int COORD_BITS_DEF = 16;

    localparam int ID_W     = 8;
    localparam int COORD_W  = 16;
    localparam int OUT_W    = 18;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ttpp_front.sv
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts touch transactions, keeps the two lowest ids of the frame and
// hands a frame record to the queue at the end of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpp_front #(
    parameter int ID_BITS    = ttpp_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = ttpp_pkg::COORD_BITS_DEF,
    parameter int FW         = 2 + 2 * ID_BITS + 4 * COORD_BITS
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [ttpp_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire  [ttpp_pkg::S_USER_W-1:0]  s_tuser,
    input  wire                            s_tlast,
    output logic                           q_push,
    output logic [FW-1:0]                  q_data,
    input  wire                            q_full
);

    localparam int IDX_W = (ID_BITS > ttpp_pkg::ID_W) ? ID_BITS : ttpp_pkg::ID_W;
    localparam int CX_W  = (COORD_BITS > ttpp_pkg::COORD_W) ? COORD_BITS : ttpp_pkg::COORD_W;

    logic                    low_v_reg, low_v_next;
    logic [ID_BITS-1:0]      low_id_reg, low_id_next;
    logic [2*COORD_BITS-1:0] low_xy_reg, low_xy_next;
    logic                    nxt_v_reg, nxt_v_next;
    logic [ID_BITS-1:0]      nxt_id_reg, nxt_id_next;
    logic [2*COORD_BITS-1:0] nxt_xy_reg, nxt_xy_next;

    logic                    accept;
    logic                    qualify;
    logic [IDX_W-1:0]        id_ext;
    logic [CX_W-1:0]         x_ext;
    logic [CX_W-1:0]         y_ext;
    logic [ID_BITS-1:0]      id;
    logic [2*COORD_BITS-1:0] xy;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign qualify  = s_tuser[0] && !s_tuser[1];
    assign id_ext   = IDX_W'(s_tdata[7:0]);
    assign x_ext    = CX_W'(s_tdata[23:8]);
    assign y_ext    = CX_W'(s_tdata[39:24]);
    assign id       = id_ext[ID_BITS-1:0];
    assign xy       = {y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};

    always_comb begin
        low_v_next  = low_v_reg;
        low_id_next = low_id_reg;
        low_xy_next = low_xy_reg;
        nxt_v_next  = nxt_v_reg;
        nxt_id_next = nxt_id_reg;
        nxt_xy_next = nxt_xy_reg;
        if (accept && qualify) begin
            if (!low_v_reg) begin
                low_v_next  = 1'b1;
                low_id_next = id;
                low_xy_next = xy;
            end else if (id < low_id_reg) begin
                nxt_v_next  = 1'b1;
                nxt_id_next = low_id_reg;
                nxt_xy_next = low_xy_reg;
                low_id_next = id;
                low_xy_next = xy;
            end else if (!nxt_v_reg || (id < nxt_id_reg)) begin
                nxt_v_next  = 1'b1;
                nxt_id_next = id;
                nxt_xy_next = xy;
            end
        end
    end

    assign q_push = accept && s_tlast;
    assign q_data = {nxt_xy_next, low_xy_next, nxt_id_next, low_id_next, nxt_v_next, low_v_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_v_reg <= 1'b0;
            nxt_v_reg <= 1'b0;
        end else if (q_push) begin
            low_v_reg <= 1'b0;
            nxt_v_reg <= 1'b0;
        end else begin
            low_v_reg <= low_v_next;
            nxt_v_reg <= nxt_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_id_reg <= low_id_next;
        low_xy_reg <= low_xy_next;
        nxt_id_reg <= nxt_id_next;
        nxt_xy_reg <= nxt_xy_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/ttpp_queue.sv
// ----------------------------------------------------------------------------
// Tracker frame queue
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpp_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ttpp_pkg::QUEUE_DEPTH
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          push,
    input  wire  [W-1:0] data_in,
    output logic         full,
    input  wire          pop,
    output logic         valid,
    output logic [W-1:0] data_out
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ttpp_isqrt.sv
// ----------------------------------------------------------------------------
// Tracker integer square root
// Restoring square root, one root bit per cycle, rounded down.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpp_isqrt #(
    parameter int N = 17
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  wire  [2*N-1:0]       radicand,
    output ttpp_pkg::sqrt_stat_t stat,
    output logic [N-1:0]         root
);

    localparam int CW = $clog2(N + 1);

    logic [2*N-1:0] rad_reg;
    logic [N:0]     rem_reg;
    logic [N-1:0]   root_reg;
    logic [CW-1:0]  cnt_reg;
    logic           done_reg;

    logic [N+1:0]   rem_t;
    logic [N+1:0]   trial;
    logic           fit;

    assign rem_t = {rem_reg[N-1:0], rad_reg[2*N-1:2*N-2]};
    assign trial = {root_reg, 2'b01};
    assign fit   = (rem_t >= trial);

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign root      = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(N);
            done_reg <= 1'b0;
        end else if (stat.busy) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (stat.busy) begin
            rad_reg <= {rad_reg[2*N-3:0], 2'b00};
            if (fit) begin
                rem_reg  <= (N+1)'(rem_t - trial);
                root_reg <= {root_reg[N-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_t[N:0];
                root_reg <= {root_reg[N-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ttpp_back.sv
// ----------------------------------------------------------------------------
// Tracker back end
// Takes frame records from the queue, computes distance and midpoint sums,
// tracks the finger pair and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpp_back #(
    parameter int ID_BITS    = ttpp_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = ttpp_pkg::COORD_BITS_DEF,
    parameter int FW         = 2 + 2 * ID_BITS + 4 * COORD_BITS
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            q_valid,
    input  wire  [FW-1:0]                  q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [ttpp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [ttpp_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int N     = COORD_BITS + 1;
    localparam int OW    = ttpp_pkg::OUT_W;
    localparam int EXT_W = (N > OW) ? N : OW;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQX  = 6'b000010,
        ST_SQY  = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic                 low_v, nxt_v;
    logic [ID_BITS-1:0]   low_id, nxt_id;
    logic [C-1:0]         ax, ay, bx, by;

    logic                 both_reg;
    logic [2*ID_BITS-1:0] pair_reg;
    logic [C-1:0]         adx_reg, ady_reg;
    logic [N-1:0]         sx_reg, sy_reg;
    logic [2*C-1:0]       sqx_reg, sqy_reg;
    logic [C-1:0]         mul_in;
    logic [2*C-1:0]       product;

    logic                 tracking_reg;
    logic [2*ID_BITS-1:0] tpair_reg;
    logic [N-1:0]         pdist_reg;
    logic [N-1:0]         psx_reg, psy_reg;

    logic                 sq_start;
    logic [2*N-1:0]       radicand;
    ttpp_pkg::sqrt_stat_t sq_stat;
    logic [N-1:0]         sq_root;

    logic                 out_free;
    logic                 same;
    logic [EXT_W-1:0]     e_dist, e_pdist, e_sx, e_psx, e_sy, e_psy;
    logic [OW-1:0]        pinch, pan_x, pan_y;

    logic                 m_tvalid_reg;
    logic [ttpp_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [ttpp_pkg::M_USER_W-1:0] m_tuser_reg;

    assign {bx, by} = {q_data[2+2*ID_BITS+2*C +: C], q_data[2+2*ID_BITS+3*C +: C]};
    assign {ax, ay} = {q_data[2+2*ID_BITS +: C], q_data[2+2*ID_BITS+C +: C]};
    assign nxt_id   = q_data[2+ID_BITS +: ID_BITS];
    assign low_id   = q_data[2 +: ID_BITS];
    assign nxt_v    = q_data[1];
    assign low_v    = q_data[0];

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !m_tvalid_reg || m_tready;

    assign mul_in   = (state_reg == ST_SQX) ? adx_reg : ady_reg;
    assign product  = mul_in * mul_in;

    assign sq_start = (state_reg == ST_SUM);
    assign radicand = (2*N)'(sqx_reg) + (2*N)'(sqy_reg);

    ttpp_isqrt #(
        .N(N)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    assign same    = tracking_reg && (tpair_reg == pair_reg);
    assign e_dist  = EXT_W'(sq_root);
    assign e_pdist = EXT_W'(pdist_reg);
    assign e_sx    = EXT_W'(sx_reg);
    assign e_psx   = EXT_W'(psx_reg);
    assign e_sy    = EXT_W'(sy_reg);
    assign e_psy   = EXT_W'(psy_reg);
    assign pinch   = e_dist[OW-1:0] - e_pdist[OW-1:0];
    assign pan_x   = e_sx[OW-1:0] - e_psx[OW-1:0];
    assign pan_y   = e_sy[OW-1:0] - e_psy[OW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (low_v && nxt_v) ? ST_SQX : ST_OUT;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: begin
                if (sq_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tracking_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                tracking_reg <= both_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    both_reg <= low_v && nxt_v;
                    pair_reg <= {nxt_id, low_id};
                    adx_reg  <= (bx >= ax) ? (bx - ax) : (ax - bx);
                    ady_reg  <= (by >= ay) ? (by - ay) : (ay - by);
                    sx_reg   <= N'(ax) + N'(bx);
                    sy_reg   <= N'(ay) + N'(by);
                end
            end
            ST_SQX: sqx_reg <= product;
            ST_SQY: sqy_reg <= product;
            ST_OUT: begin
                if (out_free) begin
                    if (both_reg) begin
                        m_tuser_reg <= 1'b1;
                        m_tdata_reg <= same ? {2'b00, pan_y, pan_x, pinch} : '0;
                        tpair_reg   <= pair_reg;
                        pdist_reg   <= sq_root;
                        psx_reg     <= sx_reg;
                        psy_reg     <= sy_reg;
                    end else begin
                        m_tuser_reg <= 1'b0;
                        m_tdata_reg <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

>>> rtl/core/two_touch_pinch_pan_tracker_top.sv
// ----------------------------------------------------------------------------
// Two-touch pinch/pan tracker
// Tracks the two lowest-id touches of each frame and reports pinch and pan
// changes against the previous frame once per frame.
//
//   Channel  Dir  Handshake          Contents
//   s_       in   s_tvalid/s_tready  touch point, tlast closes the frame
//   m_       out  m_tvalid/m_tready  one gesture result per frame
//
// The front end takes one transaction per cycle while the frame queue has room.
// The back end takes a frame with two touches through the SQX, SQY, SUM and
// ROOT states, where the square root unit resolves one root bit per cycle, and
// then to ST_OUT; a frame without goes from ST_IDLE straight to ST_OUT. Reset
// is synchronous and active low and clears the tracking flag. A stalled result
// holds in the output register while the back end finishes the next frame and
// up to two further frames wait in the queue before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_touch_pinch_pan_tracker_top_macros.svh"

module two_touch_pinch_pan_tracker_top #(
    parameter int ID_BITS    = ttpp_pkg::ID_BITS_DEF,
    parameter int COORD_BITS = ttpp_pkg::COORD_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // touch_id [7:0], touch_x [23:8], touch_y [39:24]
    input  wire  [ttpp_pkg::S_DATA_W-1:0]  s_tdata,
    // has_touch [0], touch_ended [1]
    input  wire  [ttpp_pkg::S_USER_W-1:0]  s_tuser,
    input  wire                            s_tlast,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // pinch_delta [17:0], pan_delta_x [35:18], pan_delta_y [53:36], zero [55:54]
    output logic [ttpp_pkg::M_DATA_W-1:0]  m_tdata,
    // gesture_active [0]
    output logic [ttpp_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int FW = 2 + 2 * ID_BITS + 4 * COORD_BITS;

    logic          q_push;
    logic [FW-1:0] q_in;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [FW-1:0] q_out;

    ttpp_front #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS),
        .FW         (FW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    ttpp_queue #(
        .W     (FW),
        .DEPTH (ttpp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .data_out (q_out)
    );

    ttpp_back #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS),
        .FW         (FW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `TTPP_ASSERT_IMP(a_full_stalls_input, aclk, aresetn, q_full, !s_tready)
    `TTPP_ASSERT_IMP(a_pop_needs_frame, aclk, aresetn, q_pop, q_valid)
    `TTPP_ASSERT_NEXT(a_push_fills_queue, aclk, aresetn, q_push, q_valid)
    `TTPP_ASSERT_IMP(a_inactive_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule

`default_nettype wire
